[rtl/cdf_pkg.sv]
package cdf_pkg;

  // Q16.16 word and its saturation limits
  typedef logic signed [31:0] q_t;
  localparam q_t Q_MAX = 32'sh7fff_ffff;
  localparam q_t Q_MIN = 32'sh8000_0000;
  localparam q_t Q_ONE = 32'sd65536;

  // Smoothing time floor (about 0.0001) and curve coefficients 0.48, 0.235
  localparam logic [30:0] ST_FLOOR = 31'd7;
  localparam logic [30:0] C_048    = 31'd31457;
  localparam logic [30:0] C_0235   = 31'd15401;

  // Divider: dividends 2^33 (omega) and 2^32 (decay factor)
  localparam int unsigned DIV_W     = 34;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
  localparam logic [DIV_W-1:0] DIV_NUM_OMEGA = 34'h2_0000_0000;
  localparam logic [DIV_W-1:0] DIV_NUM_K     = 34'h1_0000_0000;

  // Register select (word address bit 2)
  localparam logic REG_DAMP_TIME = 1'b0;
  localparam logic REG_MAX_SPEED = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_OMEGA_GO,
    ST_OMEGA_WAIT,
    ST_X_MUL,
    ST_X_WR,
    ST_X2_MUL,
    ST_X2_WR,
    ST_X3_MUL,
    ST_X3_WR,
    ST_D2_MUL,
    ST_D2_WR,
    ST_D3_MUL,
    ST_D3_WR,
    ST_K_GO,
    ST_K_WAIT,
    ST_LIM_MUL,
    ST_LIM_WR,
    ST_ERR,
    ST_CLAMP,
    ST_A_MUL,
    ST_A_WR,
    ST_T_MUL,
    ST_T_WR,
    ST_C_MUL,
    ST_C_WR,
    ST_V_MUL,
    ST_V_WR,
    ST_G_MUL,
    ST_G_WR,
    ST_DONE
  } state_t;

  // Saturating add of two Q16.16 words
  function automatic q_t sat_add(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s > 33'sh0_7fff_ffff) return Q_MAX;
    else if (s < 33'sh1_8000_0000) return Q_MIN;
    else return s[31:0];
  endfunction

  // Saturating subtract a - b
  function automatic q_t sat_sub(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s > 33'sh0_7fff_ffff) return Q_MAX;
    else if (s < 33'sh1_8000_0000) return Q_MIN;
    else return s[31:0];
  endfunction

  // Saturate a scaled product down to a Q16.16 word
  function automatic q_t sat_wide(input logic signed [48:0] v);
    if (v > 49'sh0_0000_7fff_ffff) return Q_MAX;
    else if (v < 49'sh1_ffff_8000_0000) return Q_MIN;
    else return v[31:0];
  endfunction

endpackage

[rtl/cdf_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle
module cdf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [cdf_pkg::DIV_W-1:0]    numer,
  input  logic [30:0]                  denom,
  output logic                         busy,
  output logic [cdf_pkg::DIV_W-1:0]    quot
);

  logic [cdf_pkg::DIV_CNT_W-1:0] cnt;
  logic [30:0]                   rem;
  logic [cdf_pkg::DIV_W-1:0]     num;
  logic [30:0]                   den;
  logic [31:0]                   trial;
  logic [31:0]                   diff;
  logic                          fits;

  // Shift in next dividend bit and try the subtract
  assign trial = {rem, num[cdf_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= cdf_pkg::DIV_CNT_W'(cdf_pkg::DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == cdf_pkg::DIV_CNT_W'(1)) busy <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      num  <= numer;
      den  <= denom;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? diff[30:0] : trial[30:0];
      num  <= {num[cdf_pkg::DIV_W-2:0], 1'b0};
      quot <= {quot[cdf_pkg::DIV_W-2:0], fits};
    end
  end

endmodule

[rtl/critically_damped_follower.sv]
// Critically damped follower: moves a Q16.16 position toward a target like a
// spring with critical damping, keeping one velocity between words.
// Input channel (in_valid/in_ready) carries current_position, target_position
// and time_step; output channel (out_valid/out_ready) returns new_position and
// the velocity stored after the step (velocity_out).
// damp_time and max_speed are written over the APB port; the user must write
// them only while idle, as the block does not enforce it. pready is always
// high; reads at paddr[1:0] == 0 return the register value, else zero.
// Each word takes two passes through a shared 1-bit-per-cycle divider (omega
// and decay factor), eleven products through one shared 33x33 multiplier, each
// formed in its MUL state, registered and then scaled and saturated in its WR
// state, the error and clamp states and a final write-back state. in_ready is
// high only in the idle state, so a new word is taken only once the last ends.
// The result sits in an output register; a stalled receiver holds it, and the
// block can accept and work on the next word meanwhile, waiting only at the
// final write-back until the old result is taken.
// Reset (synchronous, active high) clears velocity to zero, sets damp_time to
// 1.0 and max_speed to its maximum, and drops out_valid.
module critically_damped_follower (
  input  logic               clk,
  input  logic               rst,
  // APB config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] current_position,
  input  logic signed [31:0] target_position,
  input  logic [30:0]        time_step,
  // output words
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] new_position,
  output logic signed [31:0] velocity_out
);

  cdf_pkg::state_t state, state_next;

  logic [30:0]   damp_time;
  logic [30:0]   max_speed;
  logic [30:0]   st;
  cdf_pkg::q_t   velocity;

  // per-word working registers
  cdf_pkg::q_t   cur, tgt;
  logic [30:0]   dt;
  logic [30:0]   omega;
  logic [16:0]   k;
  cdf_pkg::q_t   x, x2, x3, d, lim, err, ctgt, acc, temp, f, v, pos;
  cdf_pkg::q_t   neg_lim;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic signed [63:0] prod;
  logic signed [47:0] prod_sh;
  logic               prod_rnd;
  logic signed [48:0] prod_adj;
  cdf_pkg::q_t        qval;

  // divider hookup
  logic                       div_start;
  logic                       div_k_sel;
  logic                       div_busy;
  logic [cdf_pkg::DIV_W-1:0]  div_numer;
  logic [30:0]                div_denom;
  logic [cdf_pkg::DIV_W-1:0]  div_quot;

  logic out_load;
  logic overshoot;
  logic cfg_wr;

  // Config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      damp_time <= 31'd65536;
      max_speed <= 31'h7fff_ffff;
    end else if (cfg_wr) begin
      case (paddr[2])
        cdf_pkg::REG_DAMP_TIME: damp_time <= pwdata[30:0];
        cdf_pkg::REG_MAX_SPEED: max_speed <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[2])
        cdf_pkg::REG_DAMP_TIME: prdata = {1'b0, damp_time};
        cdf_pkg::REG_MAX_SPEED: prdata = {1'b0, max_speed};
        default:                prdata = '0;
      endcase
    end
  end

  // Floor on smoothing time
  assign st = (damp_time < cdf_pkg::ST_FLOOR) ? cdf_pkg::ST_FLOOR : damp_time;

  // Divider: omega = 2^33/st, k = 2^32/d
  assign div_k_sel = (state == cdf_pkg::ST_K_GO);
  assign div_numer = div_k_sel ? cdf_pkg::DIV_NUM_K : cdf_pkg::DIV_NUM_OMEGA;
  assign div_denom = div_k_sel ? d[30:0] : st;

  cdf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      cdf_pkg::ST_X_MUL:   begin mul_a = {2'b00, omega};          mul_b = {2'b00, dt};   end
      cdf_pkg::ST_X2_MUL:  begin mul_a = {x[31], x};              mul_b = {x[31], x};    end
      cdf_pkg::ST_X3_MUL:  begin mul_a = {x2[31], x2};            mul_b = {x[31], x};    end
      cdf_pkg::ST_D2_MUL:  begin mul_a = {2'b00, cdf_pkg::C_048}; mul_b = {x2[31], x2};  end
      cdf_pkg::ST_D3_MUL:  begin mul_a = {2'b00, cdf_pkg::C_0235}; mul_b = {x3[31], x3}; end
      cdf_pkg::ST_LIM_MUL: begin mul_a = {2'b00, st};             mul_b = {2'b00, max_speed}; end
      cdf_pkg::ST_A_MUL:   begin mul_a = {2'b00, omega};          mul_b = {err[31], err}; end
      cdf_pkg::ST_T_MUL:   begin mul_a = {acc[31], acc};          mul_b = {2'b00, dt};   end
      cdf_pkg::ST_C_MUL:   begin mul_a = {2'b00, omega};          mul_b = {temp[31], temp}; end
      cdf_pkg::ST_V_MUL:   begin mul_a = {acc[31], acc};          mul_b = {16'd0, k};    end
      cdf_pkg::ST_G_MUL:   begin mul_a = {f[31], f};              mul_b = {16'd0, k};    end
      default:             begin mul_a = '0;                      mul_b = '0;            end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= mul_full[63:0];
  end

  // Scale by 2^-16 truncating toward zero, then saturate
  assign prod_sh  = prod[63:16];
  assign prod_rnd = prod[63] && (prod[15:0] != 16'd0);
  assign prod_adj = {prod_sh[47], prod_sh} + {48'd0, prod_rnd};
  assign qval     = cdf_pkg::sat_wide(prod_adj);

  assign neg_lim  = -lim;

  // Overshoot: target side of current matches new position past target
  assign overshoot = (tgt > cur) == (pos > tgt);

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= cdf_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Sequencer
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      cdf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = cdf_pkg::ST_OMEGA_GO;
      end
      cdf_pkg::ST_OMEGA_GO: begin
        div_start  = 1'b1;
        state_next = cdf_pkg::ST_OMEGA_WAIT;
      end
      cdf_pkg::ST_OMEGA_WAIT: if (!div_busy) state_next = cdf_pkg::ST_X_MUL;
      cdf_pkg::ST_X_MUL:      state_next = cdf_pkg::ST_X_WR;
      cdf_pkg::ST_X_WR:       state_next = cdf_pkg::ST_X2_MUL;
      cdf_pkg::ST_X2_MUL:     state_next = cdf_pkg::ST_X2_WR;
      cdf_pkg::ST_X2_WR:      state_next = cdf_pkg::ST_X3_MUL;
      cdf_pkg::ST_X3_MUL:     state_next = cdf_pkg::ST_X3_WR;
      cdf_pkg::ST_X3_WR:      state_next = cdf_pkg::ST_D2_MUL;
      cdf_pkg::ST_D2_MUL:     state_next = cdf_pkg::ST_D2_WR;
      cdf_pkg::ST_D2_WR:      state_next = cdf_pkg::ST_D3_MUL;
      cdf_pkg::ST_D3_MUL:     state_next = cdf_pkg::ST_D3_WR;
      cdf_pkg::ST_D3_WR:      state_next = cdf_pkg::ST_K_GO;
      cdf_pkg::ST_K_GO: begin
        div_start  = 1'b1;
        state_next = cdf_pkg::ST_K_WAIT;
      end
      cdf_pkg::ST_K_WAIT:     if (!div_busy) state_next = cdf_pkg::ST_LIM_MUL;
      cdf_pkg::ST_LIM_MUL:    state_next = cdf_pkg::ST_LIM_WR;
      cdf_pkg::ST_LIM_WR:     state_next = cdf_pkg::ST_ERR;
      cdf_pkg::ST_ERR:        state_next = cdf_pkg::ST_CLAMP;
      cdf_pkg::ST_CLAMP:      state_next = cdf_pkg::ST_A_MUL;
      cdf_pkg::ST_A_MUL:      state_next = cdf_pkg::ST_A_WR;
      cdf_pkg::ST_A_WR:       state_next = cdf_pkg::ST_T_MUL;
      cdf_pkg::ST_T_MUL:      state_next = cdf_pkg::ST_T_WR;
      cdf_pkg::ST_T_WR:       state_next = cdf_pkg::ST_C_MUL;
      cdf_pkg::ST_C_MUL:      state_next = cdf_pkg::ST_C_WR;
      cdf_pkg::ST_C_WR:       state_next = cdf_pkg::ST_V_MUL;
      cdf_pkg::ST_V_MUL:      state_next = cdf_pkg::ST_V_WR;
      cdf_pkg::ST_V_WR:       state_next = cdf_pkg::ST_G_MUL;
      cdf_pkg::ST_G_MUL:      state_next = cdf_pkg::ST_G_WR;
      cdf_pkg::ST_G_WR:       state_next = cdf_pkg::ST_DONE;
      cdf_pkg::ST_DONE: begin
        // write back once the output register is free
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = cdf_pkg::ST_IDLE;
        end
      end
      default: state_next = cdf_pkg::ST_IDLE;
    endcase
  end

  // Working registers, one step per state
  always_ff @(posedge clk) begin
    case (state)
      cdf_pkg::ST_IDLE: begin
        if (in_valid) begin
          cur <= current_position;
          tgt <= target_position;
          dt  <= time_step;
        end
      end
      cdf_pkg::ST_OMEGA_WAIT: if (!div_busy) omega <= div_quot[30:0];
      cdf_pkg::ST_X_WR: begin
        x <= qval;
        d <= cdf_pkg::sat_add(cdf_pkg::Q_ONE, qval);
      end
      cdf_pkg::ST_X2_WR:  x2 <= qval;
      cdf_pkg::ST_X3_WR:  x3 <= qval;
      cdf_pkg::ST_D2_WR:  d  <= cdf_pkg::sat_add(d, qval);
      cdf_pkg::ST_D3_WR:  d  <= cdf_pkg::sat_add(d, qval);
      cdf_pkg::ST_K_WAIT: if (!div_busy) k <= div_quot[16:0];
      cdf_pkg::ST_LIM_WR: lim <= qval;
      cdf_pkg::ST_ERR:    err <= cdf_pkg::sat_sub(cur, tgt);
      cdf_pkg::ST_CLAMP: begin
        if (err > lim)          err <= lim;
        else if (err < neg_lim) err <= neg_lim;
      end
      cdf_pkg::ST_A_MUL:  ctgt <= cdf_pkg::sat_sub(cur, err);
      cdf_pkg::ST_A_WR:   acc  <= cdf_pkg::sat_add(velocity, qval);
      cdf_pkg::ST_T_WR:   temp <= qval;
      cdf_pkg::ST_C_MUL:  f    <= cdf_pkg::sat_add(err, temp);
      cdf_pkg::ST_C_WR:   acc  <= cdf_pkg::sat_sub(velocity, qval);
      cdf_pkg::ST_V_WR:   v    <= qval;
      cdf_pkg::ST_G_WR:   pos  <= cdf_pkg::sat_add(ctgt, qval);
      cdf_pkg::ST_DONE: begin
        if (out_load) new_position <= overshoot ? tgt : pos;
      end
      default: ;
    endcase
  end

  // Velocity state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      velocity  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        velocity  <= overshoot ? '0 : v;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // velocity only changes together with the output register
  assign velocity_out = velocity;

endmodule
